// ===== rtl/gtpc_pkg.sv =====
// ----------------------------------------------------------------------------
// gtpc_pkg
// Shared types and constants of the pile counter: field widths, parameter
// defaults, sequencer states and the words passed between the modules.
// ----------------------------------------------------------------------------
package gtpc_pkg;

	localparam int MAX_PILES_DEF  = 1024;
	localparam int VALUE_BITS_DEF = 32;
	localparam int VALUE_BITS_MAX = 64;

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 11;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SRCH  = 3'b010,
		ST_WRITE = 3'b100
	} state_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} ram_ctl_t;

	typedef struct packed {
		logic [COUNT_W-1:0] pile_count;
		logic               overflow;
		logic               final_res;
	} res_t;

endpackage

// ===== rtl/gtpc_if.sv =====
// ----------------------------------------------------------------------------
// gtpc_if
// Valid/ready channels of the pile counter: input words and result words.
// ----------------------------------------------------------------------------
interface gtpc_in_if;
	logic                        valid;
	logic                        ready;
	logic [gtpc_pkg::VALUE_W-1:0] value;
	logic                        last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

interface gtpc_out_if;
	logic                        valid;
	logic                        ready;
	logic [gtpc_pkg::COUNT_W-1:0] pile_count;
	logic                        overflow;
	logic                        final_res;

	modport source (output valid, output pile_count, output overflow, output final_res,
		input ready);
	modport sink (input valid, input pile_count, input overflow, input final_res,
		output ready);
endinterface

// ===== rtl/gtpc_tops_ram.sv =====
// ----------------------------------------------------------------------------
// gtpc_tops_ram
// Single-port-write, single-port-read store of pile tops, registered read.
// ----------------------------------------------------------------------------
module gtpc_tops_ram #(
	parameter int DEPTH  = gtpc_pkg::MAX_PILES_DEF,
	parameter int DATA_W = gtpc_pkg::VALUE_BITS_DEF,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                clk,
	input  gtpc_pkg::ram_ctl_t  ctl,
	input  logic [ADDR_W-1:0]   rd_addr,
	input  logic [ADDR_W-1:0]   wr_addr,
	input  logic [DATA_W-1:0]   wr_data,
	output logic [DATA_W-1:0]   rd_data
);
	import gtpc_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/gtpc_ctrl.sv =====
// ----------------------------------------------------------------------------
// gtpc_ctrl
// Search sequencer: binary search over the sorted tops, one memory read per
// cycle, then one write-back and the result word.
// ----------------------------------------------------------------------------
module gtpc_ctrl #(
	parameter int MAX_PILES  = gtpc_pkg::MAX_PILES_DEF,
	parameter int VALUE_BITS = gtpc_pkg::VALUE_BITS_DEF,
	parameter int ADDR_W     = (MAX_PILES > 1) ? $clog2(MAX_PILES) : 1,
	parameter int CNT_W      = $clog2(MAX_PILES + 1)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	gtpc_in_if.sink                 din,
	input  logic                    out_free,
	output logic                    res_load,
	output gtpc_pkg::res_t          res,
	output gtpc_pkg::ram_ctl_t      ram_ctl,
	output logic [ADDR_W-1:0]       rd_addr,
	output logic [ADDR_W-1:0]       wr_addr,
	output logic [VALUE_BITS-1:0]   wr_data,
	input  logic [VALUE_BITS-1:0]   rd_data
);
	import gtpc_pkg::*;

	localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_PILES);

	state_t                state_q, state_d;
	logic [VALUE_BITS-1:0] v_q;
	logic                  fin_q;
	logic [CNT_W-1:0]      lo_q, hi_q, mid_q, piles_q;
	logic                  ovf_q;

	logic                         accept;
	logic [VALUE_BITS_MAX-1:0]    v_wide;
	logic                         gt;
	logic [CNT_W-1:0]             lo_n, hi_n, mid_n, new_cnt;
	logic                         new_pile, full_drop, ovf_n;
	logic [CNT_W+COUNT_W-1:0]     cnt_ext;

	assign accept    = din.valid && din.ready;
	assign din.ready = (state_q == ST_IDLE);
	assign v_wide    = VALUE_BITS_MAX'(din.value);

	assign gt    = rd_data > v_q;
	assign lo_n  = gt ? lo_q : mid_q + CNT_W'(1);
	assign hi_n  = gt ? mid_q : hi_q;
	assign mid_n = lo_n + ((hi_n - lo_n) >> 1);

	assign new_pile  = (lo_q == piles_q) && (piles_q != MaxCnt);
	assign full_drop = (lo_q == piles_q) && (piles_q == MaxCnt);
	assign new_cnt   = new_pile ? piles_q + CNT_W'(1) : piles_q;
	assign ovf_n     = ovf_q | full_drop;
	assign cnt_ext   = {{COUNT_W{1'b0}}, new_cnt};

	assign res_load       = (state_q == ST_WRITE) && out_free;
	assign res.pile_count = cnt_ext[COUNT_W-1:0];
	assign res.overflow   = ovf_n;
	assign res.final_res  = fin_q;

	assign wr_addr = lo_q[ADDR_W-1:0];
	assign wr_data = v_q;

	always_comb begin
		state_d       = state_q;
		ram_ctl.rd_en = 1'b0;
		ram_ctl.wr_en = 1'b0;
		rd_addr       = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ram_ctl.rd_en = (piles_q != '0);
					rd_addr       = ADDR_W'(piles_q >> 1);
					state_d       = (piles_q != '0) ? ST_SRCH : ST_WRITE;
				end
			end
			ST_SRCH: begin
				ram_ctl.rd_en = (lo_n < hi_n);
				rd_addr       = mid_n[ADDR_W-1:0];
				if (!(lo_n < hi_n)) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (out_free) begin
					ram_ctl.wr_en = !full_drop;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			piles_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				piles_q <= fin_q ? '0 : new_cnt;
				ovf_q   <= fin_q ? 1'b0 : ovf_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			v_q   <= v_wide[VALUE_BITS-1:0];
			fin_q <= din.last;
			lo_q  <= '0;
			hi_q  <= piles_q;
			mid_q <= piles_q >> 1;
		end else if (state_q == ST_SRCH) begin
			lo_q  <= lo_n;
			hi_q  <= hi_n;
			mid_q <= mid_n;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		piles_q <= MaxCnt)
		else $error("pile count beyond capacity");

	a_search_open: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SRCH |-> (lo_q < hi_q) && (hi_q <= piles_q))
		else $error("search window empty or past the pile count");

	a_write_pos: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WRITE |-> lo_q <= piles_q)
		else $error("write position beyond the pile count");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> state_q == ST_IDLE && !res_load)
		else $error("second result for one word");

endmodule

// ===== rtl/greedy_tower_pile_counter.sv =====
// ----------------------------------------------------------------------------
// greedy_tower_pile_counter
// Patience-sorting pile counter: one result word per input word.
// ----------------------------------------------------------------------------
// Each input word is placed by a binary search over the sorted pile tops,
// held in a synchronous memory with one read per cycle. The search, when
// there are piles, runs until its window is empty; then, once the output
// register is free, the top is written back (unless all piles are full
// and the word starts no pile) and the result word is loaded into the
// output register. The next word is taken the cycle after the result is
// loaded, even while that result still waits to be taken, so a new word
// is not accepted while the last one is still being placed. The word
// marked last clears the count and the overflow flag for the next
// sequence.
module greedy_tower_pile_counter #(
	parameter int MAX_PILES  = gtpc_pkg::MAX_PILES_DEF,
	parameter int VALUE_BITS = gtpc_pkg::VALUE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	gtpc_in_if.sink    din,
	gtpc_out_if.source dout
);
	import gtpc_pkg::*;

	localparam int ADDR_W = (MAX_PILES > 1) ? $clog2(MAX_PILES) : 1;
	localparam int CNT_W  = $clog2(MAX_PILES + 1);

	ram_ctl_t              ram_ctl;
	logic [ADDR_W-1:0]     rd_addr, wr_addr;
	logic [VALUE_BITS-1:0] wr_data, rd_data;
	logic                  out_free, res_load;
	res_t                  res, res_q;
	logic                  valid_q;

	assign out_free = !valid_q || dout.ready;

	gtpc_ctrl #(
		.MAX_PILES  (MAX_PILES),
		.VALUE_BITS (VALUE_BITS),
		.ADDR_W     (ADDR_W),
		.CNT_W      (CNT_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.din      (din),
		.out_free (out_free),
		.res_load (res_load),
		.res      (res),
		.ram_ctl  (ram_ctl),
		.rd_addr  (rd_addr),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_data  (rd_data)
	);

	gtpc_tops_ram #(
		.DEPTH  (MAX_PILES),
		.DATA_W (VALUE_BITS),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk     (clk),
		.ctl     (ram_ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= res_load || (valid_q && !dout.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

	assign dout.valid      = valid_q;
	assign dout.pile_count = res_q.pile_count;
	assign dout.overflow   = res_q.overflow;
	assign dout.final_res  = res_q.final_res;

endmodule

// ===== tb/greedy_tower_pile_counter_tb.sv =====
// ----------------------------------------------------------------------------
// greedy_tower_pile_counter_tb
// Self-checking bench for the pile counter. Value words are placed on piles
// by a model of the greedy search with its own store of pile tops, and every
// result word is checked against the oldest prediction. Directed words cover
// the field extremes, equal and falling values; random sequences of several
// shapes and a long output stall follow, under three patterns of idling on
// both channels.
// ----------------------------------------------------------------------------
module greedy_tower_pile_counter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gtpc_pkg::*;

	localparam int PILE_CAP = MAX_PILES_DEF;

	typedef enum int {MIX_ANY, MIX_NARROW, MIX_RISING, MIX_BITS} mix_t;

	class pile_count_checker;
		logic [VALUE_W-1:0] tops [PILE_CAP];
		int unsigned        piles;
		bit                 ovf;
		res_t               expected_counts [$];
		int unsigned        mismatches;

		function new();
			piles      = 0;
			ovf        = 1'b0;
			mismatches = 0;
		endfunction

		function void place_word(logic [VALUE_W-1:0] v, logic fin);
			int unsigned lo;
			int unsigned hi;
			int unsigned mid;
			res_t        r;
			lo = 0;
			hi = piles;
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if (tops[mid] > v) begin
					hi = mid;
				end else begin
					lo = mid + 1;
				end
			end
			if (lo < piles) begin
				tops[lo] = v;
			end else if (piles < PILE_CAP) begin
				tops[piles] = v;
				piles++;
			end else begin
				ovf = 1'b1;
			end
			r.pile_count = COUNT_W'(piles);
			r.overflow   = ovf;
			r.final_res  = fin;
			expected_counts.insert(expected_counts.size(), r);
			if (fin) begin
				piles = 0;
				ovf   = 1'b0;
			end
		endfunction

		function void check_count(res_t got);
			res_t want;
			if (expected_counts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: unexpected result word: count %0d overflow %0b final %0b",
						$realtime, got.pile_count, got.overflow, got.final_res);
				end
				return;
			end
			want = expected_counts.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: result mismatch: count %0d/%0d overflow %0b/%0b final %0b/%0b",
						$realtime, want.pile_count, got.pile_count, want.overflow,
						got.overflow, want.final_res, got.final_res);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	gtpc_in_if  din_if ();
	gtpc_out_if dout_if ();

	pile_count_checker board = new();

	int src_idle_pct;
	int snk_idle_pct;
	bit hold_req;

	greedy_tower_pile_counter DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	task automatic send_word(input logic [VALUE_W-1:0] v, input logic fin);
		while ($urandom_range(99) < src_idle_pct) begin
			din_if.valid <= 1'b0;
			@(posedge clk);
		end
		din_if.valid <= 1'b1;
		din_if.value <= v;
		din_if.last  <= fin;
		do @(posedge clk); while (!din_if.ready);
		board.place_word(v, fin);
	endtask

	task automatic directed_words();
		send_word('0, 1'b1);
		send_word('1, 1'b0);
		send_word('0, 1'b0);
		send_word('0, 1'b0);
		send_word(32'd5, 1'b0);
		send_word(32'd5, 1'b0);
		send_word('1, 1'b0);
		send_word('1, 1'b1);
		send_word(32'd100, 1'b0);
		send_word(32'd50, 1'b0);
		send_word(32'd20, 1'b0);
		send_word(32'd10, 1'b1);
		send_word(32'd7, 1'b0);
		send_word(32'd7, 1'b0);
		send_word(32'd7, 1'b0);
		send_word(32'd7, 1'b1);
		send_word(32'hAAAA_AAAA, 1'b0);
		send_word(32'h5555_5555, 1'b0);
		send_word(32'h8000_0000, 1'b0);
		send_word(32'h7FFF_FFFF, 1'b1);
	endtask

	task automatic random_sequences(input int n_words);
		int                 sent;
		int                 len;
		mix_t               mix;
		logic [VALUE_W-1:0] v;
		logic [VALUE_W-1:0] run;
		sent = 0;
		while (sent < n_words) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(150, 60) : $urandom_range(30, 1);
			mix = mix_t'($urandom_range(3));
			run = $urandom_range(1000);
			for (int i = 0; i < len; i++) begin
				case (mix)
					MIX_ANY: begin
						v = $urandom;
					end
					MIX_NARROW: begin
						v = $urandom_range(15);
					end
					MIX_RISING: begin
						run = run + $urandom_range(50);
						v = ($urandom_range(4) == 0) ? $urandom_range(run) : run;
					end
					default: begin
						case ($urandom_range(3))
							0: v = '0;
							1: v = '1;
							2: v = 32'h1 << $urandom_range(31);
							default: v = ~(32'h1 << $urandom_range(31));
						endcase
					end
				endcase
				send_word(v, i == len - 1);
			end
			sent += len;
		end
	endtask

	initial begin
		int   hold_left;
		res_t got;
		hold_left = 0;
		dout_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && dout_if.valid && dout_if.ready) begin
				got.pile_count = dout_if.pile_count;
				got.overflow   = dout_if.overflow;
				got.final_res  = dout_if.final_res;
				board.check_count(got);
			end
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				dout_if.ready <= 1'b0;
			end else begin
				dout_if.ready <= ($urandom_range(99) >= snk_idle_pct);
			end
		end
	end

	initial begin
		arst_n       <= 1'b0;
		din_if.valid <= 1'b0;
		din_if.value <= '0;
		din_if.last  <= 1'b0;
		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_req     = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct = 26;
		snk_idle_pct = 67;
		directed_words();
		random_sequences(190);

		src_idle_pct = 67;
		snk_idle_pct = 26;
		random_sequences(190);

		// no idling; long output stall backs the block up
		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_req     = 1'b1;
		random_sequences(60);
		random_sequences(160);
		din_if.valid <= 1'b0;

		while (board.expected_counts.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (board.mismatches == 0 && board.expected_counts.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
